### design/utf8_byte_decoder_defines.svh
// ------------------------------------------------------------------------
// utf8_byte_decoder_defines
// assertion macros shared by the decoder's checker
// ------------------------------------------------------------------------
`ifndef UTF8_BYTE_DECODER_DEFINES_SVH
`define UTF8_BYTE_DECODER_DEFINES_SVH

// implication in the same cycle, quiet while reset is high
`define UTF8D_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication in the next cycle, quiet while reset is high
`define UTF8D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// implication in the next cycle, checked through reset as well
`define UTF8D_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/utf8d_pkg.sv
// ------------------------------------------------------------------------
// utf8d_pkg
// types and constants shared by the utf-8 byte decoder
// ------------------------------------------------------------------------
package utf8d_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;

   localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

   // following bytes still claimed by an open sequence
   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_ONE   = 2'd1;
   localparam logic [1:0] PEND_TWO   = 2'd2;
   localparam logic [1:0] PEND_THREE = 2'd3;

   // decoder state carried from byte to byte
   typedef struct packed {
      logic [1:0]      pending;
      logic [CP_W-1:0] partial;
   } dec_state_type;

   // one decoded code point
   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            final_point;
   } dec_result_type;

endpackage

### design/utf8d_decode.sv
// ------------------------------------------------------------------------
// utf8d_decode
// combinational step: one byte against the current decoder state
// ------------------------------------------------------------------------
module utf8d_decode (
   input  utf8d_pkg::dec_state_type  state_cur,
   input  logic [7:0]                text_byte,
   input  logic                      last_byte,
   output utf8d_pkg::dec_state_type  state_nxt,
   output logic                      emit,
   output utf8d_pkg::dec_result_type result
);
   import utf8d_pkg::*;

   logic [CP_W-1:0] shifted;
   logic [1:0]      pend_dec;

   // continuation: shift in six payload bits, prefix not checked
   assign shifted  = {state_cur.partial[CP_W-7:0], text_byte[5:0]};
   assign pend_dec = state_cur.pending - 2'd1;

   always_comb begin
      state_nxt          = state_cur;
      emit               = 1'b0;
      result.code_point  = '0;
      result.final_point = last_byte;

      priority if (state_cur.pending != PEND_NONE) begin
         // inside a sequence, any byte counts as a following byte
         state_nxt.partial = shifted;
         state_nxt.pending = pend_dec;
         if ((pend_dec == PEND_NONE) || last_byte) begin
            state_nxt.pending = PEND_NONE;
            emit              = 1'b1;
            result.code_point = shifted;
         end
      end else if (text_byte[7] == 1'b0) begin
         // plain ascii
         emit              = 1'b1;
         result.code_point = {{(CP_W-BYTE_W){1'b0}}, text_byte};
      end else if (text_byte[7:5] == 3'b110) begin
         state_nxt.partial = {{(CP_W-5){1'b0}}, text_byte[4:0]};
         state_nxt.pending = PEND_ONE;
      end else if (text_byte[7:4] == 4'b1110) begin
         state_nxt.partial = {{(CP_W-4){1'b0}}, text_byte[3:0]};
         state_nxt.pending = PEND_TWO;
      end else if (text_byte[7:3] == 5'b11110) begin
         state_nxt.partial = {{(CP_W-3){1'b0}}, text_byte[2:0]};
         state_nxt.pending = PEND_THREE;
      end else begin
         // stray continuation or over-long lead
         emit              = 1'b1;
         result.code_point = CP_REPLACEMENT;
      end

      // text ends on a lead byte: payload bits go out alone
      if (!emit && last_byte && (state_cur.pending == PEND_NONE)) begin
         state_nxt.pending = PEND_NONE;
         emit              = 1'b1;
         result.code_point = state_nxt.partial;
      end
   end

endmodule

### design/utf8_byte_decoder.sv
// ------------------------------------------------------------------------
// utf8_byte_decoder
// streaming utf-8 decoder, one text byte per transfer
// ------------------------------------------------------------------------
// Bytes enter an input register, are decoded against the open sequence by a
// short combinational step, and a completed code point lands in a result
// register. The block takes one byte every clock for as long as the result
// side keeps up. The byte that completes a code point is held in the input
// register until the result register is free, and the code point is then
// registered there and offered. A byte with req_last_byte set always yields
// one code point with rsp_final_point set and closes any open sequence.
// ------------------------------------------------------------------------
module utf8_byte_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic        rsp_final_point
);
   import utf8d_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   dec_state_type  state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   dec_result_type out_ff;
   logic           out_free, fire, emit;
   dec_result_type result;

   // result register free or emptied this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   utf8d_decode u_decode (
      .state_cur (state_ff),
      .text_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .state_nxt (state_in),
      .emit      (emit),
      .result    (result)
   );

   // input register
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.pending <= PEND_NONE;
         state_ff.partial <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (fire && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (fire && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_point  = out_ff.code_point;
   assign rsp_final_point = out_ff.final_point;

endmodule

### design/utf8d_checker.sv
// ------------------------------------------------------------------------
// utf8d_checker
// port-level checks on the utf-8 byte decoder, bound to the top level
// ------------------------------------------------------------------------
`include "utf8_byte_decoder_defines.svh"

module utf8d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_text_byte,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [20:0] rsp_code_point,
   input logic        rsp_final_point
);

   // a stalled result holds
   `UTF8D_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_code_point) && $stable(rsp_final_point),
      "result changed while stalled")

   // a waiting byte holds until its transfer
   `UTF8D_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready,
      req_valid && $stable(req_text_byte) && $stable(req_last_byte),
      "request changed while waiting")

   // no result straight out of reset
   `UTF8D_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "result valid after reset")

   // a draining result side never blocks input
   `UTF8D_ASSERT_SAME(a_ready_flow, clock, reset, rsp_ready, req_ready,
      "input blocked while result side ready")

   // a fresh result comes from an earlier byte transfer
   `UTF8D_ASSERT_SAME(a_rsp_origin, clock, reset, $rose(rsp_valid),
      $past(req_valid && req_ready, 2), "result without a matching byte")

endmodule

bind utf8_byte_decoder utf8d_checker u_utf8d_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_text_byte   (req_text_byte),
   .req_last_byte   (req_last_byte),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_code_point  (rsp_code_point),
   .rsp_final_point (rsp_final_point)
);
